### hdl/ttd_pkg.sv
// Shared types and constants for the texture texel decoder.
package ttd_pkg;

  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_HEIGHT        = 1024;
  localparam int ROW_W             = $clog2(MAX_HEIGHT);
  localparam int POS_W             = 13;   // byte position within a row
  localparam int CFG_DATA_W        = 13;   // widest register (row stride)
  localparam int CFG_IDX_W         = 3;
  localparam int QDEPTH            = 4;

  typedef enum logic [1:0] {
    FMT_RGBA = 2'd0,
    FMT_IA   = 2'd1,
    FMT_I    = 2'd2,
    FMT_CI   = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    SZ_4  = 2'd0,
    SZ_8  = 2'd1,
    SZ_16 = 2'd2,
    SZ_32 = 2'd3
  } sz_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT  = 3'd0,
    REG_SIZE    = 3'd1,
    REG_WIDTH   = 3'd2,
    REG_HEIGHT  = 3'd3,
    REG_STRIDE  = 3'd4,
    REG_PALETTE = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ENT_TEXEL   = 1'b0,
    ENT_PALETTE = 1'b1
  } ent_kind_t;

  typedef struct packed {
    fmt_t        pixel_format;
    sz_t         texel_size;
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [12:0] row_stride_bytes;
    logic [8:0]  palette_entries;
  } cfg_t;

  // Queue entry: a raw texel value or a palette write {index, word}.
  typedef struct packed {
    ent_kind_t   kind;
    logic        status;
    logic        eor;
    logic        eoi;
    logic [31:0] value;
  } qent_t;

endpackage

### hdl/ttd_front.sv
// Front end: configuration registers, row walk and texel extraction from source bytes.
module ttd_front #(
  parameter int MAX_WIDTH = ttd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [7:0]                     in_data_byte,
  input  logic [7:0]                     in_palette_index,
  input  logic [15:0]                    in_palette_word,
  input  logic                           q_room,
  output logic                           push0,
  output logic                           push1,
  output ttd_pkg::qent_t                 ent0,
  output ttd_pkg::qent_t                 ent1,
  output ttd_pkg::cfg_t                  cfg
);
  import ttd_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  cfg_t               cfg_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [23:0]        held_r, held_nxt;

  logic               accept, byte_go;
  logic [12:0]        rb, stride;
  logic               pair_ok, cfg_ok;
  logic [12:0]        col1, col2;
  logic [10:0]        row1;
  logic               last_row, eor0, eoi0, eor1, eoi1;
  logic               in_row, emit0, emit1, done;
  logic [31:0]        v0, v1;
  logic [13:0]        pos_inc;

  assign cfg      = cfg_r;
  assign in_stall = !q_room;
  assign accept   = in_valid && !in_stall;
  assign byte_go  = accept && (in_mode == 1'b0);

  always_comb begin
    case (cfg_r.texel_size)
      SZ_4:    rb = (13'(cfg_r.image_width) + 13'd1) >> 1;
      SZ_8:    rb = 13'(cfg_r.image_width);
      SZ_16:   rb = 13'(cfg_r.image_width) << 1;
      default: rb = 13'(cfg_r.image_width) << 2;
    endcase
    case (cfg_r.pixel_format)
      FMT_RGBA: pair_ok = (cfg_r.texel_size == SZ_16) || (cfg_r.texel_size == SZ_32);
      FMT_IA:   pair_ok = (cfg_r.texel_size != SZ_32);
      default:  pair_ok = (cfg_r.texel_size == SZ_4) || (cfg_r.texel_size == SZ_8);
    endcase
    cfg_ok = pair_ok
          && !(cfg_r.pixel_format == FMT_CI && cfg_r.palette_entries == 9'd0)
          && (cfg_r.image_width != 11'd0)
          && (13'(cfg_r.image_width) <= 13'(MAX_WIDTH))
          && (cfg_r.image_height != 11'd0)
          && (cfg_r.image_height <= 11'(MAX_HEIGHT))
          && !(cfg_r.row_stride_bytes != 13'd0 && cfg_r.row_stride_bytes < rb);
    stride = (cfg_r.row_stride_bytes != 13'd0) ? cfg_r.row_stride_bytes : rb;
  end

  // Row and image end flags for the first and, in 4-bit mode, the second texel.
  always_comb begin
    col1     = 13'(col_r) + 13'd1;
    col2     = 13'(col_r) + 13'd2;
    row1     = 11'(row_r) + 11'd1;
    last_row = (row1 >= cfg_r.image_height);
    eor0     = (col1 >= 13'(cfg_r.image_width));
    eoi0     = eor0 && last_row;
    eor1     = (col2 >= 13'(cfg_r.image_width));
    eoi1     = eor1 && last_row;
  end

  always_comb begin
    in_row   = (pos_r < rb);
    emit0    = 1'b0;
    emit1    = 1'b0;
    v0       = 32'd0;
    v1       = 32'd0;
    held_nxt = held_r;
    if (in_row) begin
      case (cfg_r.texel_size)
        SZ_4: begin
          emit0 = 1'b1;
          emit1 = !eor0;
          v0    = {28'd0, in_data_byte[7:4]};
          v1    = {28'd0, in_data_byte[3:0]};
        end
        SZ_8: begin
          emit0 = 1'b1;
          v0    = {24'd0, in_data_byte};
        end
        SZ_16: begin
          if (pos_r[0] == 1'b0) begin
            held_nxt = {16'd0, in_data_byte};
          end else begin
            emit0 = 1'b1;
            v0    = {16'd0, held_r[7:0], in_data_byte};
          end
        end
        default: begin
          if (pos_r[1:0] != 2'd3) begin
            held_nxt = {held_r[15:0], in_data_byte};
          end else begin
            emit0 = 1'b1;
            v0    = {held_r, in_data_byte};
          end
        end
      endcase
    end

    col_nxt = col_r;
    row_nxt = row_r;
    done    = 1'b0;
    if (emit1) begin
      col_nxt = eor1 ? '0 : col2[CW-1:0];
      row_nxt = eor1 ? row1[ROW_W-1:0] : row_r;
      done    = eoi1;
    end else if (emit0) begin
      col_nxt = eor0 ? '0 : col1[CW-1:0];
      row_nxt = eor0 ? row1[ROW_W-1:0] : row_r;
      done    = eoi0;
    end

    pos_inc = 14'(pos_r) + 14'd1;
    pos_nxt = (pos_inc >= 14'(stride)) ? '0 : pos_inc[POS_W-1:0];
    if (done) begin
      pos_nxt  = '0;
      col_nxt  = '0;
      row_nxt  = '0;
      held_nxt = '0;
    end
  end

  // Queue pushes.
  always_comb begin
    push0        = 1'b0;
    push1        = 1'b0;
    ent0.kind    = ENT_TEXEL;
    ent0.status  = 1'b0;
    ent0.eor     = eor0;
    ent0.eoi     = eoi0;
    ent0.value   = v0;
    ent1.kind    = ENT_TEXEL;
    ent1.status  = 1'b0;
    ent1.eor     = eor1;
    ent1.eoi     = eoi1;
    ent1.value   = v1;
    if (accept && in_mode) begin
      push0      = 1'b1;
      ent0.kind  = ENT_PALETTE;
      ent0.eor   = 1'b0;
      ent0.eoi   = 1'b0;
      ent0.value = {8'd0, in_palette_index, in_palette_word};
    end else if (byte_go && !cfg_ok) begin
      push0       = 1'b1;
      ent0.status = 1'b1;
      ent0.eor    = 1'b0;
      ent0.eoi    = 1'b0;
      ent0.value  = 32'd0;
    end else if (byte_go) begin
      push0 = emit0;
      push1 = emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format     <= FMT_RGBA;
      cfg_r.texel_size       <= SZ_16;
      cfg_r.image_width      <= 11'd1;
      cfg_r.image_height     <= 11'd1;
      cfg_r.row_stride_bytes <= 13'd0;
      cfg_r.palette_entries  <= 9'd0;
      pos_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORMAT:  cfg_r.pixel_format     <= fmt_t'(cfg_data[1:0]);
        REG_SIZE:    cfg_r.texel_size       <= sz_t'(cfg_data[1:0]);
        REG_WIDTH:   cfg_r.image_width      <= cfg_data[10:0];
        REG_HEIGHT:  cfg_r.image_height     <= cfg_data[10:0];
        REG_STRIDE:  cfg_r.row_stride_bytes <= cfg_data[12:0];
        REG_PALETTE: cfg_r.palette_entries  <= cfg_data[8:0];
        default: ;
      endcase
      // restart the walk on any register write
      if (cfg_index <= REG_PALETTE) begin
        pos_r  <= '0;
        col_r  <= '0;
        row_r  <= '0;
        held_r <= '0;
      end
    end else if (byte_go && cfg_ok) begin
      pos_r  <= pos_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

### hdl/ttd_queue.sv
// Short queue between front and back: up to two pushes and one pop per cycle.
module ttd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push0,
  input  logic           push1,
  input  ttd_pkg::qent_t ent0,
  input  ttd_pkg::qent_t ent1,
  input  logic           pop,
  output ttd_pkg::qent_t head,
  output logic           head_valid,
  output logic           room
);
  import ttd_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  qent_t          slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [QAW:0]   count_r, count_nxt;

  assign wr_ptr1    = wr_ptr_r + QAW'(1);
  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  // keep room for a full two-texel push
  assign room       = (count_r <= (QAW+1)'(QDEPTH - 2));

  always_comb begin
    count_nxt = count_r + (QAW+1)'(push0) + (QAW+1)'(push1) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) slot_r[wr_ptr_r] <= ent0;
    if (push1) slot_r[wr_ptr1]  <= ent1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push1)      wr_ptr_r <= wr_ptr_r + QAW'(2);
      else if (push0) wr_ptr_r <= wr_ptr1;
      if (pop)        rd_ptr_r <= rd_ptr_r + QAW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

### hdl/ttd_back.sv
// Back end: palette memory, channel expansion and the output register.
module ttd_back #(
  parameter int PALETTE_DEPTH = ttd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ttd_pkg::cfg_t  cfg,
  input  ttd_pkg::qent_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_alpha,
  output logic           out_end_of_row,
  output logic           out_end_of_image,
  output logic           out_status
);
  import ttd_pkg::*;

  localparam int         PAW       = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction
  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction
  function automatic logic [7:0] widen3(input logic [2:0] v);
    return {v, v, v[2:1]};
  endfunction
  function automatic logic [7:0] widen1(input logic v);
    return {8{v}};
  endfunction

  logic [15:0]  pal_mem [PALETTE_DEPTH];
  logic [15:0]  pal_rd_r;

  logic         s1_valid_r;
  qent_t        s1_r;
  logic         s1_inrange_r;
  logic         out_free, s1_adv;
  logic [8:0]   head_idx, wr_idx;
  logic         head_inrange;

  logic [7:0]   c_r, c_g, c_b, c_a, inten;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign pop      = head_valid && (!s1_valid_r || out_free);

  assign head_idx     = {1'b0, head.value[7:0]};
  assign wr_idx       = {1'b0, head.value[23:16]};
  assign head_inrange = (head_idx < cfg.palette_entries) && (head_idx < PAL_LIMIT);

  // Palette writes take effect in queue order, after earlier lookups.
  always_ff @(posedge clk) begin
    if (pop && head.kind == ENT_PALETTE && wr_idx < PAL_LIMIT) begin
      pal_mem[head.value[16+PAW-1:16]] <= head.value[15:0];
    end
    if (pop && head.kind == ENT_TEXEL) begin
      pal_rd_r <= pal_mem[head.value[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r         <= head;
      s1_inrange_r <= head_inrange;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pop) begin
      s1_valid_r <= (head.kind == ENT_TEXEL);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_comb begin
    c_r   = 8'd0;
    c_g   = 8'd0;
    c_b   = 8'd0;
    c_a   = 8'd0;
    inten = 8'd0;
    case (cfg.pixel_format)
      FMT_RGBA: begin
        if (cfg.texel_size == SZ_16) begin
          c_r = widen5(s1_r.value[15:11]);
          c_g = widen5(s1_r.value[10:6]);
          c_b = widen5(s1_r.value[5:1]);
          c_a = widen1(s1_r.value[0]);
        end else begin
          c_r = s1_r.value[31:24];
          c_g = s1_r.value[23:16];
          c_b = s1_r.value[15:8];
          c_a = s1_r.value[7:0];
        end
      end
      FMT_IA: begin
        case (cfg.texel_size)
          SZ_16: begin
            inten = s1_r.value[15:8];
            c_a   = s1_r.value[7:0];
          end
          SZ_8: begin
            inten = widen4(s1_r.value[7:4]);
            c_a   = widen4(s1_r.value[3:0]);
          end
          default: begin
            inten = widen3(s1_r.value[3:1]);
            c_a   = widen1(s1_r.value[0]);
          end
        endcase
        c_r = inten;
        c_g = inten;
        c_b = inten;
      end
      FMT_I: begin
        inten = (cfg.texel_size == SZ_8) ? s1_r.value[7:0] : widen4(s1_r.value[3:0]);
        c_r   = inten;
        c_g   = inten;
        c_b   = inten;
        c_a   = inten;
      end
      default: begin
        if (s1_inrange_r) begin
          c_r = widen5(pal_rd_r[15:11]);
          c_g = widen5(pal_rd_r[10:6]);
          c_b = widen5(pal_rd_r[5:1]);
          c_a = widen1(pal_rd_r[0]);
        end
      end
    endcase
    if (s1_r.status) begin
      c_r = 8'd0;
      c_g = 8'd0;
      c_b = 8'd0;
      c_a = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_red          <= c_r;
      out_green        <= c_g;
      out_blue         <= c_b;
      out_alpha        <= c_a;
      out_end_of_row   <= s1_r.eor;
      out_end_of_image <= s1_r.eoi;
      out_status       <= s1_r.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hdl/texture_texel_decode.sv
// Top level of the texture texel decoder: front end, queue and back end.
//
// Input channel (in_*): one transaction per unstalled cycle, a source byte
// (in_mode 0) or a palette write (in_mode 1, in_palette_index/in_palette_word).
// Output channel (out_*): one RGBA8888 texel per transaction with row end,
// image end and status flags. A source byte gives zero, one or two texels;
// a palette write gives none.
// Configuration: cfg_we writes cfg_data into register cfg_index; change it
// only while no texels are in flight. Writes to indices 0-5 restart the walk.
// A texel passes the queue, the lookup stage and the output register before
// it appears on out_valid. Throughput: one byte per unstalled cycle for 8, 16
// and 32-bit formats; 4-bit formats produce up to two texels per byte, more
// than the single output register drains, so the queue fills. in_stall rises
// when the four-entry queue cannot take a two-texel byte.
// When out_stall is high the output register holds, the back end holds its
// lookup stage, and the queue fills until in_stall stops the source.
// Reset clears the walk, the queue and the output valid; registers return
// to their defaults. Palette contents are undefined until written.
module texture_texel_decode #(
  parameter int MAX_WIDTH     = ttd_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = ttd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [7:0]                     in_data_byte,
  input  logic [7:0]                     in_palette_index,
  input  logic [15:0]                    in_palette_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_end_of_row,
  output logic                           out_end_of_image,
  output logic                           out_status
);
  import ttd_pkg::*;

  cfg_t  cfg;
  qent_t ent0, ent1, head;
  logic  push0, push1, pop, head_valid, q_room;

  ttd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .in_palette_index (in_palette_index),
    .in_palette_word  (in_palette_word),
    .q_room           (q_room),
    .push0            (push0),
    .push1            (push1),
    .ent0             (ent0),
    .ent1             (ent1),
    .cfg              (cfg)
  );

  ttd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (push0),
    .push1      (push1),
    .ent0       (ent0),
    .ent1       (ent1),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (q_room)
  );

  ttd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_image (out_end_of_image),
    .out_status       (out_status)
  );

endmodule
